FILE: src/tzat_pkg.sv
package tzat_pkg;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;
  localparam int ENTRY_COUNT = 8;

  localparam logic [2:0] REG_OFFSET_ENC     = 3'd0;
  localparam logic [2:0] REG_ZONE_COUNT     = 3'd1;
  localparam logic [2:0] REG_ZONE_LIMITS    = 3'd2;
  localparam logic [2:0] REG_THROTTLE_LIMIT = 3'd3;
  localparam logic [2:0] REG_SHUTDOWN_LIMIT = 3'd4;

  localparam logic        RST_OFFSET_ENC     = 1'b0;
  localparam logic [3:0]  RST_ZONE_COUNT     = 4'd1;
  localparam logic [63:0] RST_ZONE_LIMITS    = 64'd0;
  localparam logic [7:0]  RST_THROTTLE_LIMIT = 8'd90;
  localparam logic [7:0]  RST_SHUTDOWN_LIMIT = 8'd115;

  localparam logic [7:0] ALERT_MASK = 8'h18;
  localparam logic [7:0] EXT_OFFSET = 8'd64;
  localparam logic [8:0] HYST       = 9'd3;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] local_raw;
    logic [7:0] remote_high_raw;
    logic [7:0] remote_low_raw;
  } alert_t;

  typedef struct packed {
    logic              handled;
    logic signed [7:0] temperature;
    logic              zone_error;
    logic              low_write;
    logic [7:0]        low_byte;
    logic              high_write;
    logic [7:0]        high_byte;
    logic              throttle_change;
    logic              throttle_on;
    logic              notify_zone;
  } result_t;

  typedef struct packed {
    logic              offset_enc;
    logic [3:0]        zone_count;
    logic [63:0]       zone_limits;
    logic signed [7:0] throttle_limit;
    logic signed [7:0] shutdown_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [8:0] active_low_limit;
    logic signed [7:0] active_high_limit;
    logic signed [7:0] last_reported_temp;
    logic              throttling;
  } track_state_t;

endpackage

FILE: src/tzat_step.sv
module tzat_step #(
  parameter int MAX_ZONES = 8
) (
  input  tzat_pkg::alert_t       alert,
  input  tzat_pkg::cfg_t         cfg,
  input  tzat_pkg::track_state_t track,
  output tzat_pkg::result_t      result,
  output tzat_pkg::track_state_t track_next
);

  logic [7:0]        local_dec;
  logic [7:0]        remote_dec;
  logic signed [7:0] t_local;
  logic signed [7:0] t_remote;
  logic signed [7:0] t_remote_adj;
  logic signed [7:0] temp;
  logic signed [8:0] temp9;
  logic signed [7:0] entry [tzat_pkg::ENTRY_COUNT];
  logic [3:0]        n_eff;
  logic [2:0]        last_idx;
  logic signed [7:0] last_entry;
  logic signed [8:0] lo;
  logic signed [7:0] hi;
  logic signed [8:0] hi9;
  logic              found;
  logic signed [8:0] thr9;
  logic signed [8:0] thr_off;
  logic              throttle_new;
  logic              alert_hit;
  logic              zone_err;
  logic              low_diff;
  logic              high_diff;
  logic [7:0]        enc_offset;

  always_comb begin
    enc_offset   = cfg.offset_enc ? tzat_pkg::EXT_OFFSET : 8'd0;
    local_dec    = alert.local_raw - enc_offset;
    remote_dec   = alert.remote_high_raw - enc_offset;
    t_local      = local_dec;
    t_remote     = remote_dec;
    if ((alert.remote_low_raw[7:6] != 2'd0) && (t_remote != 8'sd127)) begin
      t_remote_adj = t_remote + 8'sd1;
    end else begin
      t_remote_adj = t_remote;
    end
    temp  = (t_local > t_remote_adj) ? t_local : t_remote_adj;
    temp9 = {temp[7], temp};
  end

  always_comb begin
    for (int i = 0; i < tzat_pkg::ENTRY_COUNT; i++) begin
      entry[i] = cfg.zone_limits[8*i +: 8];
    end
    if (cfg.zone_count == 4'd0) begin
      n_eff = 4'd1;
    end else if (cfg.zone_count > 4'(MAX_ZONES)) begin
      n_eff = 4'(MAX_ZONES);
    end else begin
      n_eff = cfg.zone_count;
    end
    last_idx   = 3'(n_eff - 4'd1);
    last_entry = entry[last_idx];
  end

  always_comb begin
    lo    = '0;
    hi    = '0;
    found = 1'b0;
    if (temp < entry[0]) begin
      lo = '0;
      hi = entry[0];
    end else if (temp >= last_entry) begin
      lo = {last_entry[7], last_entry} - tzat_pkg::HYST;
      hi = cfg.shutdown_limit;
    end else begin
      for (int i = 0; i + 1 < MAX_ZONES; i++) begin
        if (!found && (4'(i + 1) < n_eff) && (temp >= entry[i]) && (temp < entry[i + 1])) begin
          lo    = {entry[i][7], entry[i]} - tzat_pkg::HYST;
          hi    = entry[i + 1];
          found = 1'b1;
        end
      end
    end
    hi9 = {hi[7], hi};
  end

  always_comb begin
    thr9    = {cfg.throttle_limit[7], cfg.throttle_limit};
    thr_off = thr9 - tzat_pkg::HYST;
    if (temp9 >= thr9) begin
      throttle_new = 1'b1;
    end else if (temp9 <= thr_off) begin
      throttle_new = 1'b0;
    end else begin
      throttle_new = track.throttling;
    end
  end

  always_comb begin
    alert_hit = (alert.status_byte & tzat_pkg::ALERT_MASK) != 8'd0;
    zone_err  = (lo == hi9);
    low_diff  = (track.active_low_limit != lo);
    high_diff = (track.active_high_limit != hi);

    result             = '0;
    result.temperature = temp;
    result.throttle_on = track.throttling;
    track_next         = track;

    if (alert_hit) begin
      result.handled         = 1'b1;
      result.throttle_on     = throttle_new;
      result.throttle_change = (throttle_new != track.throttling);
      track_next.throttling  = throttle_new;
      if (zone_err) begin
        result.zone_error = 1'b1;
      end else if (low_diff || high_diff) begin
        if (low_diff) begin
          result.low_write            = 1'b1;
          result.low_byte             = lo[7:0] + enc_offset;
          track_next.active_low_limit = lo;
        end
        if (high_diff) begin
          result.high_write            = 1'b1;
          result.high_byte             = hi + enc_offset;
          track_next.active_high_limit = hi;
        end
        result.notify_zone            = (track.last_reported_temp != temp);
        track_next.last_reported_temp = temp;
      end
    end
  end

endmodule

FILE: src/thermal_zone_alert_tracker_top.sv
// Thermal zone alert tracker.
// Input channel: one alert transaction (status, local, remote integer and
// remote fraction bytes) on alert/alert_valid, held off by alert_stall.
// Output channel: one result transaction per alert on result/result_valid,
// held off by result_stall from the receiver.
// An alert accepted into the input register passes through the zone lookup,
// throttle hysteresis and limit compare, which are combinational, into the
// result register. Throughput is one alert per cycle while result_stall is
// low; the tracked limits and throttle state update as each alert moves into
// the result register, so the next alert sees them at once.
// A stalled result holds in place; the input register takes one more alert,
// then alert_stall rises until the result is taken.
// Configuration registers sit on an APB port at byte address 8 * index
// (offset_enc, zone_count, zone_limits, throttle_limit,
// shutdown_limit), 64-bit data, pready tied high; write only while idle.
// Reset clears both pipeline registers, restores the register defaults and
// sets the tracked limits and last reported temperature to minus one.
module thermal_zone_alert_tracker_top #(
  parameter int MAX_ZONES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          alert_valid,
  output logic                          alert_stall,
  input  tzat_pkg::alert_t              alert,
  output logic                          result_valid,
  input  logic                          result_stall,
  output tzat_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tzat_pkg::ADDR_W-1:0]   paddr,
  input  logic [tzat_pkg::DATA_W-1:0]   pwdata,
  output logic [tzat_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  tzat_pkg::cfg_t         cfg;
  tzat_pkg::track_state_t track;
  tzat_pkg::track_state_t track_next;
  tzat_pkg::result_t      step_result;
  tzat_pkg::alert_t       stage;
  logic                   stage_valid;
  logic                   advance;
  logic                   cfg_write;
  logic [2:0]             reg_idx;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[5:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_enc     <= tzat_pkg::RST_OFFSET_ENC;
      cfg.zone_count     <= tzat_pkg::RST_ZONE_COUNT;
      cfg.zone_limits    <= tzat_pkg::RST_ZONE_LIMITS;
      cfg.throttle_limit <= tzat_pkg::RST_THROTTLE_LIMIT;
      cfg.shutdown_limit <= tzat_pkg::RST_SHUTDOWN_LIMIT;
    end else if (cfg_write) begin
      case (reg_idx)
        tzat_pkg::REG_OFFSET_ENC:     cfg.offset_enc     <= pwdata[0];
        tzat_pkg::REG_ZONE_COUNT:     cfg.zone_count     <= pwdata[3:0];
        tzat_pkg::REG_ZONE_LIMITS:    cfg.zone_limits    <= pwdata;
        tzat_pkg::REG_THROTTLE_LIMIT: cfg.throttle_limit <= pwdata[7:0];
        tzat_pkg::REG_SHUTDOWN_LIMIT: cfg.shutdown_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tzat_pkg::REG_OFFSET_ENC:     prdata = {63'd0, cfg.offset_enc};
      tzat_pkg::REG_ZONE_COUNT:     prdata = {60'd0, cfg.zone_count};
      tzat_pkg::REG_ZONE_LIMITS:    prdata = cfg.zone_limits;
      tzat_pkg::REG_THROTTLE_LIMIT: prdata = {56'd0, cfg.throttle_limit};
      tzat_pkg::REG_SHUTDOWN_LIMIT: prdata = {56'd0, cfg.shutdown_limit};
      default:                      prdata = '0;
    endcase
  end

  assign advance     = !result_valid || !result_stall;
  assign alert_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!alert_stall) begin
      stage_valid <= alert_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!alert_stall && alert_valid) begin
      stage <= alert;
    end
  end

  tzat_step #(
    .MAX_ZONES(MAX_ZONES)
  ) u_step (
    .alert      (stage),
    .cfg        (cfg),
    .track      (track),
    .result     (step_result),
    .track_next (track_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid             <= 1'b0;
      track.active_low_limit   <= '1;
      track.active_high_limit  <= '1;
      track.last_reported_temp <= '1;
      track.throttling         <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid;
      if (stage_valid) begin
        track <= track_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      result <= step_result;
    end
  end

  a_throttle_tracks : assert property (@(posedge clk) disable iff (rst)
    (advance && stage_valid) |=> (result.throttle_on == track.throttling))
    else $error("result throttle_on differs from tracked throttle state");

  a_throttle_change : assert property (@(posedge clk) disable iff (rst)
    (advance && stage_valid) |=>
      (result.throttle_change == (track.throttling != $past(track.throttling))))
    else $error("throttle_change does not match a toggle of the throttle state");

  a_idle_result : assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.handled) |->
      !(result.zone_error || result.low_write || result.high_write ||
        result.throttle_change || result.notify_zone))
    else $error("unhandled alert carries flags");

  a_notify_needs_write : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.notify_zone) |->
      ((result.low_write || result.high_write) && !result.zone_error))
    else $error("notify without a limit write");

  a_stall_needs_stage : assert property (@(posedge clk) disable iff (rst)
    alert_stall |-> (stage_valid && result_valid))
    else $error("input held off with an empty pipeline");

endmodule
